### sv/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`endif

### sv/prfpe_pkg.sv
// Package: payload types and fixed-point constants of the PageRank engine.
`timescale 1ns / 1ps
`default_nettype none
package prfpe_pkg;
  localparam int NODE_MAX = 1024;
  localparam int EDGE_MAX = 8192;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_RUN   = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;
  localparam logic [1:0] MODE_CLEAR = 2'd3;

  localparam logic [1:0] REG_NODES = 2'd0;
  localparam logic [1:0] REG_ITERS = 2'd1;
  localparam logic [1:0] REG_ERROR = 2'd2;

  localparam logic [31:0] Q_ONE  = 32'd1073741824;
  localparam logic [31:0] Q_DAMP = 32'd912680550;
  localparam logic [31:0] Q_BASE = 32'd161061274;
  localparam logic [21:0] SCALED_CAP = 22'd4000000;
  localparam logic [19:0] MILLION = 20'd1000000;

  typedef struct packed {
    logic [1:0] mode;
    logic [9:0] src_node;
    logic [9:0] dst_node;
  } in_req_t;

  typedef struct packed {
    logic [31:0] rank_value;
    logic [21:0] scaled_error;
    logic [15:0] rounds_done;
    logic        edges_dropped;
  } out_req_t;
endpackage
`default_nettype wire

### sv/prfpe_queue.sv
// Two-entry request queue between the front end and the engine.
`timescale 1ns / 1ps
`default_nettype none
module prfpe_queue import prfpe_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire in_req_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         empty_o,
  output in_req_t      pop_data_o
);
  in_req_t     mem_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  assign full_o     = cnt_q == 2'd2;
  assign empty_o    = cnt_q == 2'd0;
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

### sv/prfpe_divider.sv
// Radix-2 restoring divider, 32-bit dividend over 32-bit divisor.
`timescale 1ns / 1ps
`default_nettype none
module prfpe_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] num_i,
  input  wire logic [31:0] den_i,
  output logic             busy_o,
  output logic [31:0]      quo_o
);
  logic [31:0] quo_q, rem_q, den_q;
  logic [5:0]  cnt_q;
  logic [32:0] trial;

  assign busy_o = cnt_q != 6'd0;
  assign quo_o  = quo_q;
  assign trial  = {rem_q, quo_q[31]} - {1'b0, den_q};

  // One quotient bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (start_i) begin
      cnt_q <= 6'd32;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i; rem_q <= '0; den_q <= den_i;
    end else if (busy_o) begin
      if (!trial[32]) begin
        rem_q <= trial[31:0]; quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]}; quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end
endmodule
`default_nettype wire

### sv/prfpe_engine.sv
// Back end: edge store, degree store, rank memories and the iteration sequencer.
`timescale 1ns / 1ps
`default_nettype none
module prfpe_engine import prfpe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  input  wire in_req_t     req_i,
  output logic             req_pop_o,
  input  wire logic [10:0] node_count_i,
  input  wire logic [15:0] iter_limit_i,
  input  wire logic [31:0] err_limit_i,
  output logic             out_valid_o,
  output out_req_t         out_o,
  input  wire logic        out_stall_i,
  output logic             busy_o
);
  localparam int NW = $clog2(NODE_MAX);
  localparam int EW = $clog2(EDGE_MAX);
  localparam int CW = $clog2(EDGE_MAX + 1);
  localparam int XW = (NW > 11) ? NW + 1 : 12;

  localparam logic [4:0] S_IDLE = 5'd0,  S_CLR = 5'd1,  S_NDIV = 5'd2,  S_BDIV = 5'd3,
                         S_INIT = 5'd4,  S_ERD = 5'd5,  S_EWT = 5'd6,   S_EMUL = 5'd7,
                         S_EDIV = 5'd8,  S_ENRD = 5'd9, S_ENWT = 5'd10, S_ENWR = 5'd11,
                         S_DRD = 5'd12,  S_DWT = 5'd13, S_DACC = 5'd14, S_CHK = 5'd15,
                         S_SC1 = 5'd16,  S_SC2 = 5'd17, S_OUT = 5'd18,  S_RRD = 5'd19,
                         S_RWT = 5'd20,  S_LD = 5'd21,  S_LDW = 5'd22, S_START = 5'd23,
                         S_EDST = 5'd24;

  logic [4:0] st_q;
  // Memories.
  logic [31:0]     rank_mem [NODE_MAX];
  logic [31:0]     next_mem [NODE_MAX];
  logic [13:0]     deg_mem  [NODE_MAX];
  logic [2*NW-1:0] edge_mem [EDGE_MAX];

  logic [CW-1:0] etot_q, eidx_q;
  logic          drop_q;
  logic          clr_rank_q;
  logic [15:0]   rounds_q, cnt_q;
  logic [XW-1:0] n_q, idx_q;
  logic [31:0]   init_q, base_q, diff_q, share_q, nrd_q, rrd_q;
  logic [13:0]   deg_q;
  logic [2*NW-1:0] erd_q;
  logic [63:0]   prod_q;
  out_req_t      out_q;
  logic          ovld_q;
  logic [13:0]   drd_q;
  in_req_t       r_q;

  logic        dv_start, dv_busy;
  logic [31:0] dv_num, dv_den, dv_quo;
  prfpe_divider u_div (.clk_i, .rst_ni, .start_i(dv_start), .num_i(dv_num),
                       .den_i(dv_den), .busy_o(dv_busy), .quo_o(dv_quo));

  // Effective node count.
  logic [XW-1:0] n_eff;
  always_comb begin
    n_eff = XW'(node_count_i);
    if (node_count_i == 11'd0) n_eff = XW'(1);
    if (XW'(node_count_i) > XW'(NODE_MAX)) n_eff = XW'(NODE_MAX);
  end

  logic [NW-1:0] es, ed, ia;
  assign es = erd_q[2*NW-1:NW];
  assign ed = erd_q[NW-1:0];
  assign ia = idx_q[NW-1:0];

  logic [32:0] add_next, add_diff;
  logic [31:0] absd;
  assign add_next = {1'b0, nrd_q} + {1'b0, share_q};
  assign absd     = (nrd_q >= rrd_q) ? nrd_q - rrd_q : rrd_q - nrd_q;
  assign add_diff = {1'b0, diff_q} + {1'b0, absd};

  logic src_ok, dst_ok;
  assign src_ok = (XW'(req_i.src_node) < n_eff) && (int'(req_i.src_node) < NODE_MAX);
  assign dst_ok = (XW'(req_i.dst_node) < n_eff) && (int'(req_i.dst_node) < NODE_MAX);

  assign req_pop_o   = (st_q == S_IDLE) && req_valid_i && !ovld_q;
  assign out_valid_o = ovld_q;
  assign out_o       = out_q;
  assign busy_o      = st_q != S_IDLE;

  always_comb begin
    dv_start = 1'b0; dv_num = Q_ONE; dv_den = 32'(n_q);
    if (st_q == S_START) dv_start = 1'b1;
    if (st_q == S_NDIV && !dv_busy) begin
      dv_start = 1'b1; dv_num = Q_BASE;
    end
    // Share division starts once the damped product and degree are registered.
    if (st_q == S_EDST) begin
      dv_start = 1'b1; dv_num = prod_q[61:30]; dv_den = 32'(deg_q);
    end
  end

  // Memory ports.
  always_ff @(posedge clk_i) begin
    erd_q <= edge_mem[eidx_q[EW-1:0]];
    drd_q <= deg_mem[st_q == S_LD ? r_q.src_node[NW-1:0] : es];
    nrd_q <= next_mem[(st_q == S_ENRD || st_q == S_ENWT) ? ed : ia];
    rrd_q <= rank_mem[(st_q == S_RRD) ? r_q.src_node[NW-1:0] :
                      (st_q == S_ERD || st_q == S_EWT) ? es : ia];
    // Zeroing pass: degrees always, ranks only after reset.
    if (st_q == S_CLR) begin
      deg_mem[ia] <= '0;
      if (clr_rank_q) rank_mem[ia] <= '0;
    end
    if (st_q == S_LDW) begin
      edge_mem[etot_q[EW-1:0]] <= {r_q.src_node[NW-1:0], r_q.dst_node[NW-1:0]};
      deg_mem[r_q.src_node[NW-1:0]] <= drd_q + 14'd1;
    end
    if (st_q == S_INIT) begin
      rank_mem[ia] <= init_q; next_mem[ia] <= base_q;
    end
    if (st_q == S_ENWR) next_mem[ed] <= add_next[32] ? 32'hFFFFFFFF : add_next[31:0];
    if (st_q == S_DACC) begin
      rank_mem[ia] <= nrd_q; next_mem[ia] <= base_q;
    end
    if (st_q == S_EMUL) prod_q <= 64'(rrd_q) * 64'(Q_DAMP);
    if (st_q == S_SC1) prod_q <= 64'(diff_q) * 64'(MILLION);
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; clr_rank_q <= 1'b1; etot_q <= '0; drop_q <= 1'b0; rounds_q <= '0;
      ovld_q <= 1'b0;
      eidx_q <= '0; idx_q <= '0; cnt_q <= '0; n_q <= '0; diff_q <= '0;
    end else begin
      if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
      case (st_q)
        S_IDLE: if (req_pop_o) begin
          r_q <= req_i;
          case (req_i.mode)
            MODE_LOAD: if (etot_q >= CW'(EDGE_MAX) || !src_ok || !dst_ok) drop_q <= 1'b1;
                       else st_q <= S_LD;
            MODE_CLEAR: begin
              etot_q <= '0; drop_q <= 1'b0; idx_q <= '0; st_q <= S_CLR;
            end
            MODE_RUN: begin n_q <= n_eff; st_q <= S_START; end
            default: st_q <= S_RRD;
          endcase
        end
        S_CLR: begin
          if (idx_q == XW'(NODE_MAX - 1)) begin
            clr_rank_q <= 1'b0; st_q <= S_IDLE;
          end else idx_q <= idx_q + XW'(1);
        end
        S_LD: st_q <= S_LDW;
        S_LDW: begin
          etot_q <= etot_q + CW'(1);
          st_q <= S_IDLE;
        end
        S_RRD: st_q <= S_RWT;
        S_RWT: begin
          out_q <= '{rank_value: (int'(r_q.src_node) < NODE_MAX) ? rrd_q : 32'd0,
                     scaled_error: '0, rounds_done: rounds_q, edges_dropped: drop_q};
          ovld_q <= 1'b1; st_q <= S_IDLE;
        end
        S_START: st_q <= S_NDIV;
        S_NDIV: if (!dv_busy) begin init_q <= dv_quo; st_q <= S_BDIV; end
        S_BDIV: if (!dv_busy) begin
          base_q <= dv_quo; idx_q <= '0; cnt_q <= '0; st_q <= S_INIT;
        end
        S_INIT: begin
          idx_q <= idx_q + XW'(1);
          if (idx_q + XW'(1) == n_q) begin eidx_q <= '0; st_q <= S_ERD; end
        end
        S_ERD: if (eidx_q == etot_q) begin
          idx_q <= '0; diff_q <= '0; st_q <= S_DRD;
        end else st_q <= S_EWT;
        S_EWT: st_q <= S_EMUL;
        S_EMUL: begin
          deg_q <= drd_q;
          if (XW'(es) >= n_q || XW'(ed) >= n_q || drd_q == 14'd0) begin
            eidx_q <= eidx_q + CW'(1); st_q <= S_ERD;
          end else st_q <= S_EDST;
        end
        S_EDST: st_q <= S_EDIV;
        S_EDIV: if (!dv_busy) begin share_q <= dv_quo; st_q <= S_ENRD; end
        S_ENRD: st_q <= S_ENWT;
        S_ENWT: st_q <= S_ENWR;
        S_ENWR: begin eidx_q <= eidx_q + CW'(1); st_q <= S_ERD; end
        S_DRD: st_q <= S_DWT;
        S_DWT: st_q <= S_DACC;
        S_DACC: begin
          diff_q <= add_diff[32] ? 32'hFFFFFFFF : add_diff[31:0];
          idx_q <= idx_q + XW'(1);
          if (idx_q + XW'(1) == n_q) begin cnt_q <= cnt_q + 16'd1; st_q <= S_CHK; end
          else st_q <= S_DRD;
        end
        S_CHK: if (cnt_q < iter_limit_i && diff_q > err_limit_i) begin
          eidx_q <= '0; st_q <= S_ERD;
        end else begin rounds_q <= cnt_q; st_q <= S_SC1; end
        S_SC1: st_q <= S_SC2;
        S_SC2: st_q <= S_OUT;
        S_OUT: if (!ovld_q) begin
          out_q <= '{rank_value: '0,
                     scaled_error: (prod_q[63:30] > 34'(SCALED_CAP)) ? SCALED_CAP
                                   : prod_q[51:30],
                     rounds_done: rounds_q, edges_dropped: drop_q};
          ovld_q <= 1'b1; st_q <= S_IDLE;
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/page_rank_fixed_point_engine.sv
// Edge loads pass engine states LD and LDW; a rank read passes RRD and RWT, which
// registers its result; the queue accepts one request a cycle while not full.
// A run's length is set by the shared divider on each edge share and by the single
// memory read ports. Reset (async, active low) starts a pass zeroing ranks and
// degrees of all NODE_MAX nodes (a clear request zeroes degrees the same way);
// registers reset to 1, 100, 1074.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module page_rank_fixed_point_engine import prfpe_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_req_t     in_data_i,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_req_t         out_data_o,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);
  logic [10:0] nodes_q; logic [15:0] iters_q; logic [31:0] err_q;

  // Configuration registers.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= 11'd1; iters_q <= 16'd100; err_q <= 32'd1074;
    end else if (cfg_valid) begin
      case (cfg_index_i)
        REG_NODES: nodes_q <= cfg_data_i[10:0];
        REG_ITERS: iters_q <= cfg_data_i[15:0];
        REG_ERROR: err_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic full, empty, pop, busy;
  in_req_t qd;
  assign in_stall = full;
  prfpe_queue u_q (.clk_i, .rst_ni, .push_i(in_valid && !full), .push_data_i(in_data_i),
                   .full_o(full), .pop_i(pop), .empty_o(empty), .pop_data_o(qd));

  prfpe_engine u_eng (
    .clk_i, .rst_ni, .req_valid_i(!empty), .req_i(qd), .req_pop_o(pop),
    .node_count_i(nodes_q), .iter_limit_i(iters_q), .err_limit_i(err_q),
    .out_valid_o(out_valid), .out_o(out_data_o), .out_stall_i(out_stall),
    .busy_o(busy));

  `ASSERT_IMP(a_pop_ok, clk_i, rst_ni, pop, !empty && !busy, "pop from empty queue or busy")
  `ASSERT_IMP(a_err_cap, clk_i, rst_ni, out_valid, out_data_o.scaled_error <= SCALED_CAP,
              "scaled error above cap")
  `ASSERT_NXT(a_hold, clk_i, rst_ni, out_valid && out_stall, out_valid && $stable(out_data_o),
              "stalled result changed")
endmodule
`default_nettype wire
